FILE: sv/ucb_pkg.sv
// ----------------------------------------------------------------------------
// ucb_pkg
// Shared types, command codes and result builders for the command bus bridge.
// ----------------------------------------------------------------------------
package ucb_pkg;

    localparam int MAX_RES = 9;
    localparam int CNT_W   = 4;

    // result kinds
    localparam logic [1:0] KIND_TX = 2'd0;
    localparam logic [1:0] KIND_WR = 2'd1;
    localparam logic [1:0] KIND_RD = 2'd2;

    // configuration register indexes
    localparam logic CFG_CONTROL_ADDR = 1'b0;
    localparam logic CFG_TIME_ADDR    = 1'b1;

    // input actions
    localparam logic ACT_RX   = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // command bytes
    localparam logic [7:0] CMD_WRITE_RND  = 8'h57; // W
    localparam logic [7:0] CMD_WRITE      = 8'h77; // w
    localparam logic [7:0] CMD_READ_RND   = 8'h52; // R
    localparam logic [7:0] CMD_READ       = 8'h72; // r
    localparam logic [7:0] CMD_WORD_WR    = 8'h41; // A
    localparam logic [7:0] CMD_WORD_RD    = 8'h5A; // Z
    localparam logic [7:0] CMD_START      = 8'h53; // S
    localparam logic [7:0] CMD_TIME       = 8'h54; // T
    localparam logic [7:0] CMD_STATUS     = 8'h46; // F
    localparam logic [7:0] CMD_ECHO       = 8'h48; // H
    localparam logic [7:0] CMD_QUIT       = 8'h51; // Q
    localparam logic [7:0] REPLY_END      = 8'h45; // E

    typedef struct packed {
        logic        action;
        logic [7:0]  rx_byte;
        logic [31:0] read_data;
    } item_t;

    typedef struct packed {
        logic        word_access;
        logic [1:0]  kind;
        logic [31:0] bus_data;
        logic [31:0] bus_address;
        logic [7:0]  tx_byte;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        res_t [MAX_RES-1:0]      res;
    } batch_t;

    function automatic res_t mk_tx(input logic [7:0] b);
        res_t r;
        r             = '0;
        r.kind        = KIND_TX;
        r.tx_byte     = b;
        return r;
    endfunction

    function automatic res_t mk_bus(input logic [1:0] k, input logic [31:0] a,
                                    input logic [31:0] d, input logic w);
        res_t r;
        r             = '0;
        r.kind        = k;
        r.bus_address = a;
        r.bus_data    = d;
        r.word_access = w;
        return r;
    endfunction

endpackage

FILE: sv/ucb_decode.sv
// ----------------------------------------------------------------------------
// ucb_decode
// Packet state machine: takes one registered item per consume and builds the
// batch of results it causes.
// ----------------------------------------------------------------------------
module ucb_decode #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           consume,
    input  ucb_pkg::item_t item,
    input  logic [31:0]    control_addr,
    input  logic [31:0]    time_addr,
    output ucb_pkg::batch_t batch
);
    import ucb_pkg::*;

    localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_WDATA,
        PH_WORDIN,
        PH_RBYTES,
        PH_RWORD,
        PH_HALT
    } phase_t;

    phase_t                phase_reg,    phase_next;
    logic [3:0]            hdr_cnt_reg,  hdr_cnt_next;
    logic [7:0]            cmd_reg,      cmd_next;
    logic [31:0]           tgt_reg,      tgt_next;
    logic [31:0]           size_reg,     size_next;
    logic [31:0]           bcnt_reg,     bcnt_next;
    logic [31:0]           wbuf_reg,     wbuf_next;
    logic [1:0]            wcnt_reg,     wcnt_next;
    logic [ADDR_WIDTH-1:0] cur_addr_reg, cur_addr_next;

    // transfer complete once cnt reaches size (and is a multiple of four for W and R), also on count wrap
    function automatic logic xfer_done(input logic [31:0] cnt, input logic [7:0] cmd,
                                       input logic [31:0] size);
        logic rnd;
        rnd = (cmd == CMD_WRITE_RND) || (cmd == CMD_READ_RND);
        if (cnt == 32'd0)
            return 1'b1;
        if (rnd)
            return (cnt[1:0] == 2'd0) && (cnt >= size);
        return cnt >= size;
    endfunction

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        cmd_next      = cmd_reg;
        tgt_next      = tgt_reg;
        size_next     = size_reg;
        bcnt_next     = bcnt_reg;
        wbuf_next     = wbuf_reg;
        wcnt_next     = wcnt_reg;
        cur_addr_next = cur_addr_reg;
        batch         = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (item.action == ACT_RX)
                begin
                    if (hdr_cnt_reg == 4'd0)
                        cmd_next = item.rx_byte;
                    else if (hdr_cnt_reg <= 4'd4)
                        tgt_next = {tgt_reg[23:0], item.rx_byte};
                    else
                        size_next = {size_reg[23:0], item.rx_byte};

                    if (hdr_cnt_reg >= 4'd8)
                    begin
                        hdr_cnt_next  = 4'd0;
                        bcnt_next     = 32'd0;
                        wbuf_next     = 32'd0;
                        wcnt_next     = 2'd0;
                        cur_addr_next = ADDR_WIDTH'(tgt_next);
                        case (cmd_next)
                            CMD_WRITE_RND, CMD_WRITE:
                            begin
                                if (size_next != 32'd0)
                                    phase_next = PH_WDATA;
                            end
                            CMD_READ_RND, CMD_READ:
                            begin
                                if (size_next != 32'd0)
                                begin
                                    phase_next   = PH_RBYTES;
                                    batch.res[0] = mk_bus(KIND_RD, tgt_next & ADDR_MASK,
                                                          32'd0, 1'b0);
                                    batch.cnt    = CNT_W'(1);
                                end
                            end
                            CMD_WORD_WR:
                                phase_next = PH_WORDIN;
                            CMD_WORD_RD:
                            begin
                                phase_next   = PH_RWORD;
                                batch.res[0] = mk_bus(KIND_RD, tgt_next & ADDR_MASK,
                                                      32'd0, 1'b1);
                                batch.cnt    = CNT_W'(1);
                            end
                            CMD_TIME:
                            begin
                                phase_next   = PH_RWORD;
                                batch.res[0] = mk_bus(KIND_RD, time_addr & ADDR_MASK,
                                                      32'd0, 1'b1);
                                batch.cnt    = CNT_W'(1);
                            end
                            CMD_STATUS:
                            begin
                                phase_next   = PH_RWORD;
                                batch.res[0] = mk_bus(KIND_RD, control_addr & ADDR_MASK,
                                                      32'd0, 1'b1);
                                batch.cnt    = CNT_W'(1);
                            end
                            CMD_START:
                            begin
                                phase_next   = PH_HEADER;
                                batch.res[0] = mk_bus(KIND_WR, control_addr & ADDR_MASK,
                                                      32'd1, 1'b1);
                                batch.res[1] = mk_bus(KIND_WR, time_addr & ADDR_MASK,
                                                      32'd0, 1'b1);
                                batch.cnt    = CNT_W'(2);
                            end
                            CMD_ECHO:
                            begin
                                phase_next   = PH_HEADER;
                                batch.res[0] = mk_tx(cmd_next);
                                batch.res[1] = mk_tx(tgt_next[31:24]);
                                batch.res[2] = mk_tx(tgt_next[23:16]);
                                batch.res[3] = mk_tx(tgt_next[15:8]);
                                batch.res[4] = mk_tx(tgt_next[7:0]);
                                batch.res[5] = mk_tx(size_next[31:24]);
                                batch.res[6] = mk_tx(size_next[23:16]);
                                batch.res[7] = mk_tx(size_next[15:8]);
                                batch.res[8] = mk_tx(size_next[7:0]);
                                batch.cnt    = CNT_W'(MAX_RES);
                            end
                            CMD_QUIT:
                            begin
                                phase_next   = PH_HALT;
                                batch.res[0] = mk_tx(REPLY_END);
                                batch.cnt    = CNT_W'(1);
                            end
                            default:
                                phase_next = PH_HEADER;
                        endcase
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                    end
                end
            end

            PH_WDATA:
            begin
                if (item.action == ACT_RX)
                begin
                    batch.res[0]  = mk_bus(KIND_WR, 32'(cur_addr_reg),
                                           {24'd0, item.rx_byte}, 1'b0);
                    batch.cnt     = CNT_W'(1);
                    bcnt_next     = bcnt_reg + 32'd1;
                    cur_addr_next = cur_addr_reg + ADDR_WIDTH'(1);
                    if (xfer_done(bcnt_next, cmd_reg, size_reg))
                        phase_next = PH_HEADER;
                end
            end

            PH_WORDIN:
            begin
                if (item.action == ACT_RX)
                begin
                    wbuf_next = {wbuf_reg[23:0], item.rx_byte};
                    if (wcnt_reg == 2'd3)
                    begin
                        batch.res[0] = mk_bus(KIND_WR, 32'(cur_addr_reg), wbuf_next, 1'b1);
                        batch.cnt    = CNT_W'(1);
                        wcnt_next    = 2'd0;
                        phase_next   = PH_HEADER;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg + 2'd1;
                    end
                end
            end

            PH_RBYTES:
            begin
                if (item.action == ACT_READ)
                begin
                    batch.res[0]  = mk_tx(item.read_data[7:0]);
                    bcnt_next     = bcnt_reg + 32'd1;
                    cur_addr_next = cur_addr_reg + ADDR_WIDTH'(1);
                    if (xfer_done(bcnt_next, cmd_reg, size_reg))
                    begin
                        phase_next = PH_HEADER;
                        batch.cnt  = CNT_W'(1);
                    end
                    else
                    begin
                        batch.res[1] = mk_bus(KIND_RD, 32'(cur_addr_next), 32'd0, 1'b0);
                        batch.cnt    = CNT_W'(2);
                    end
                end
            end

            PH_RWORD:
            begin
                if (item.action == ACT_READ)
                begin
                    batch.res[0] = mk_tx(item.read_data[31:24]);
                    batch.res[1] = mk_tx(item.read_data[23:16]);
                    batch.res[2] = mk_tx(item.read_data[15:8]);
                    batch.res[3] = mk_tx(item.read_data[7:0]);
                    batch.cnt    = CNT_W'(4);
                    phase_next   = PH_HEADER;
                end
            end

            PH_HALT:
                phase_next = PH_HALT;

            default:
                phase_next = PH_HEADER;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            cmd_reg      <= '0;
            tgt_reg      <= '0;
            size_reg     <= '0;
            bcnt_reg     <= '0;
            wbuf_reg     <= '0;
            wcnt_reg     <= '0;
            cur_addr_reg <= '0;
        end
        else if (consume)
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            cmd_reg      <= cmd_next;
            tgt_reg      <= tgt_next;
            size_reg     <= size_next;
            bcnt_reg     <= bcnt_next;
            wbuf_reg     <= wbuf_next;
            wcnt_reg     <= wcnt_next;
            cur_addr_reg <= cur_addr_next;
        end
    end

endmodule

FILE: sv/ucb_outbuf.sv
// ----------------------------------------------------------------------------
// ucb_outbuf
// Result register: holds one item's batch and shifts it out one word a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ucb_outbuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  ucb_pkg::batch_t batch,
    input  logic            out_ready,
    output logic            out_valid,
    output ucb_pkg::res_t   out_res,
    output logic            out_last,
    output logic            free
);
    import ucb_pkg::*;

    logic [CNT_W-1:0]   cnt_reg;
    res_t [MAX_RES-1:0] res_reg;
    logic               take;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = res_reg[0];
    assign out_last  = (cnt_reg == CNT_W'(1));
    assign take      = out_valid && out_ready;
    // room for a new batch once the final word goes out
    assign free      = !out_valid || (out_last && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load && batch.cnt != '0)
            cnt_reg <= batch.cnt;
        else if (take)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load && batch.cnt != '0)
            res_reg <= batch.res;
        else if (take)
            res_reg <= {res_t'('0), res_reg[MAX_RES-1:1]};
    end

endmodule

FILE: sv/uart_command_bus_bridge.sv
// ----------------------------------------------------------------------------
// uart_command_bus_bridge
// Serial packet to memory bus bridge: header decode, byte and word transfers.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                          | contents
//  s_*      | in  | tvalid tready tdata[39:0] tuser  | rx byte / bus read data
//  m_*      | out | tvalid tready tdata[71:0] tuser  | tx byte / bus write / read
//           |     | tlast                            | last word of an item
//  cfg_*    | in  | we index data[31:0]              | control / time address
//
//  An item waits in the input register until the result register is free;
//  its results then load and leave one word per cycle while m_tready is
//  high. An item with n results holds the input side until the last one goes
//  out (9 at most, for the header echo); one with none loads nothing. Reset
//  clears the packet state and loads default configuration addresses; a stall
//  on m_tready backs up into s_tready once the input register is full.
// ----------------------------------------------------------------------------
module uart_command_bus_bridge #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] read_data
    input  logic        s_tuser,   // [0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] tx_byte, [39:8] bus_address, [71:40] bus_data
    output logic [2:0]  m_tuser,   // [1:0] kind, [2] word_access
    output logic        m_tlast,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import ucb_pkg::*;

    logic [31:0] control_addr_reg;
    logic [31:0] time_addr_reg;
    logic        in_vld_reg;
    item_t       item_reg;
    logic        consume;
    logic        ob_free;
    batch_t      batch;
    res_t        head;

    assign consume  = in_vld_reg && ob_free;
    assign s_tready = !in_vld_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_addr_reg <= 32'h0A00_0000;
            time_addr_reg    <= 32'h0A00_0004;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTROL_ADDR: control_addr_reg <= cfg_data;
                CFG_TIME_ADDR:    time_addr_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.action    <= s_tuser;
            item_reg.rx_byte   <= s_tdata[7:0];
            item_reg.read_data <= s_tdata[39:8];
        end
    end

    ucb_decode #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .consume      (consume),
        .item         (item_reg),
        .control_addr (control_addr_reg),
        .time_addr    (time_addr_reg),
        .batch        (batch)
    );

    ucb_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume),
        .batch     (batch),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (head),
        .out_last  (m_tlast),
        .free      (ob_free)
    );

    assign m_tdata = {head.bus_data, head.bus_address, head.tx_byte};
    assign m_tuser = {head.word_access, head.kind};

    // an item waiting in the input register is neither lost nor altered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !consume |=> in_vld_reg && $stable(item_reg))
        else $error("input register changed before consume");

    // a new input word is taken over a full input register only when it drains
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && in_vld_reg |-> ob_free)
        else $error("input register overrun");

    // only the three defined result kinds leave the block
    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == KIND_TX || m_tuser[1:0] == KIND_WR ||
                      m_tuser[1:0] == KIND_RD))
        else $error("undefined result kind");

endmodule

FILE: tb/bridge_reply_checker.sv
// ----------------------------------------------------------------------------
// bridge_reply_checker
// Watches the input, output and configuration ports of the command bus
// bridge, predicts the words that each accepted input word causes, and
// compares every accepted output word against the oldest prediction.
// ----------------------------------------------------------------------------
module bridge_reply_checker #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] read_data
    input  logic        s_tuser,   // [0] action

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [7:0] tx_byte, [39:8] bus_address, [71:40] bus_data
    input  logic [2:0]  m_tuser,   // [1:0] kind, [2] word_access
    input  logic        m_tlast,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,

    output int          error_count,
    output int          pending,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ucb_pkg::*;

    localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_WR_DATA,
        ST_WORD_IN,
        ST_RD_BYTES,
        ST_RD_WORD,
        ST_HALTED
    } link_state_t;

    typedef struct packed {
        res_t r;
        logic last;
    } reply_t;

    reply_t      replies_due[$];
    res_t        step_results[$];

    link_state_t link_state;
    logic [3:0]  hdr_idx;
    logic [7:0]  opcode;
    logic [31:0] base_addr;
    logic [31:0] length;
    logic [31:0] xfer_cnt;
    logic [31:0] word_acc;
    logic [1:0]  word_idx;
    logic [31:0] ctrl_addr;
    logic [31:0] time_addr;

    function automatic res_t bus_op(input logic [1:0] k, input logic [31:0] a,
                                    input logic [31:0] d, input logic w);
        res_t r;
        r             = '0;
        r.kind        = k;
        r.bus_address = a & ADDR_MASK;
        r.bus_data    = d;
        r.word_access = w;
        return r;
    endfunction

    function automatic res_t serial_byte(input logic [7:0] b);
        res_t r;
        r         = '0;
        r.kind    = KIND_TX;
        r.tx_byte = b;
        return r;
    endfunction

    function automatic void send_word_msb(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            step_results.push_back(serial_byte(w[8*i +: 8]));
    endfunction

    // a transfer also ends when the byte counter wraps to zero
    function automatic bit transfer_complete(input logic [31:0] cnt);
        if (cnt == 32'd0)
            return 1'b1;
        if (opcode == CMD_WRITE_RND || opcode == CMD_READ_RND)
            return cnt[1:0] == 2'd0 && cnt >= length;
        return cnt >= length;
    endfunction

    function automatic void start_command();
        xfer_cnt   = '0;
        word_acc   = '0;
        word_idx   = '0;
        link_state = ST_HEADER;
        case (opcode)
            CMD_WRITE_RND, CMD_WRITE:
                if (length != 32'd0)
                    link_state = ST_WR_DATA;
            CMD_READ_RND, CMD_READ:
                if (length != 32'd0)
                begin
                    link_state = ST_RD_BYTES;
                    step_results.push_back(bus_op(KIND_RD, base_addr, '0, 1'b0));
                end
            CMD_WORD_WR:
                link_state = ST_WORD_IN;
            CMD_WORD_RD:
            begin
                link_state = ST_RD_WORD;
                step_results.push_back(bus_op(KIND_RD, base_addr, '0, 1'b1));
            end
            CMD_TIME:
            begin
                link_state = ST_RD_WORD;
                step_results.push_back(bus_op(KIND_RD, time_addr, '0, 1'b1));
            end
            CMD_STATUS:
            begin
                link_state = ST_RD_WORD;
                step_results.push_back(bus_op(KIND_RD, ctrl_addr, '0, 1'b1));
            end
            CMD_START:
            begin
                step_results.push_back(bus_op(KIND_WR, ctrl_addr, 32'd1, 1'b1));
                step_results.push_back(bus_op(KIND_WR, time_addr, 32'd0, 1'b1));
            end
            CMD_ECHO:
            begin
                // echo carries the full address, not the masked one
                step_results.push_back(serial_byte(opcode));
                send_word_msb(base_addr);
                send_word_msb(length);
            end
            CMD_QUIT:
            begin
                step_results.push_back(serial_byte(REPLY_END));
                link_state = ST_HALTED;
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_replies(input logic act, input logic [7:0] rx,
                                            input logic [31:0] rd);
        reply_t e;
        step_results.delete();
        if (act == ACT_RX)
        begin
            case (link_state)
                ST_HEADER:
                begin
                    if (hdr_idx == 4'd0)
                        opcode = rx;
                    else if (hdr_idx <= 4'd4)
                        base_addr = {base_addr[23:0], rx};
                    else
                        length = {length[23:0], rx};
                    if (hdr_idx >= 4'd8)
                    begin
                        hdr_idx = 4'd0;
                        start_command();
                    end
                    else
                        hdr_idx = hdr_idx + 4'd1;
                end
                ST_WR_DATA:
                begin
                    step_results.push_back(bus_op(KIND_WR, base_addr + xfer_cnt,
                                                  {24'd0, rx}, 1'b0));
                    xfer_cnt = xfer_cnt + 32'd1;
                    if (transfer_complete(xfer_cnt))
                        link_state = ST_HEADER;
                end
                ST_WORD_IN:
                begin
                    word_acc = {word_acc[23:0], rx};
                    if (word_idx == 2'd3)
                    begin
                        step_results.push_back(bus_op(KIND_WR, base_addr, word_acc, 1'b1));
                        word_idx   = 2'd0;
                        link_state = ST_HEADER;
                    end
                    else
                        word_idx = word_idx + 2'd1;
                end
                default: ;  // serial byte while a read is pending is dropped
            endcase
        end
        else
        begin
            case (link_state)
                ST_RD_BYTES:
                begin
                    step_results.push_back(serial_byte(rd[7:0]));
                    xfer_cnt = xfer_cnt + 32'd1;
                    if (transfer_complete(xfer_cnt))
                        link_state = ST_HEADER;
                    else
                        step_results.push_back(bus_op(KIND_RD, base_addr + xfer_cnt,
                                                      '0, 1'b0));
                end
                ST_RD_WORD:
                begin
                    send_word_msb(rd);
                    link_state = ST_HEADER;
                end
                default: ;  // read data with no read pending is ignored
            endcase
        end
        foreach (step_results[i])
        begin
            e.r    = step_results[i];
            e.last = (i == step_results.size() - 1);
            replies_due.push_back(e);
        end
    endfunction

    function automatic void check_result();
        reply_t want;
        res_t   got;
        got.tx_byte     = m_tdata[7:0];
        got.bus_address = m_tdata[39:8];
        got.bus_data    = m_tdata[71:40];
        got.kind        = m_tuser[1:0];
        got.word_access = m_tuser[2];
        checked++;
        if (replies_due.size() == 0)
        begin
            if (error_count < 10)
                $display("tb: unexpected word %0d: kind %0d tx %02h addr %08h data %08h",
                         checked, got.kind, got.tx_byte, got.bus_address, got.bus_data);
            error_count++;
            return;
        end
        want = replies_due.pop_front();
        if (got.kind !== want.r.kind || got.tx_byte !== want.r.tx_byte
            || got.bus_address !== want.r.bus_address || got.bus_data !== want.r.bus_data
            || got.word_access !== want.r.word_access || m_tlast !== want.last)
        begin
            if (error_count < 10)
            begin
                $display("tb: mismatch on word %0d, expected kind %0d tx %02h addr %08h",
                         checked, want.r.kind, want.r.tx_byte, want.r.bus_address);
                $display("tb:   data %08h word %0b last %0b", want.r.bus_data,
                         want.r.word_access, want.last);
                $display("tb:   got kind %0d tx %02h addr %08h data %08h word %0b last %0b",
                         got.kind, got.tx_byte, got.bus_address, got.bus_data,
                         got.word_access, m_tlast);
            end
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_state = ST_HEADER;
            hdr_idx    = '0;
            opcode     = '0;
            base_addr  = '0;
            length     = '0;
            xfer_cnt   = '0;
            word_acc   = '0;
            word_idx   = '0;
            ctrl_addr  = 32'h0A00_0000;
            time_addr  = 32'h0A00_0004;
            replies_due.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_CONTROL_ADDR)
                    ctrl_addr = cfg_data;
                else
                    time_addr = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_replies(s_tuser, s_tdata[7:0], s_tdata[39:8]);
            if (m_tvalid && m_tready)
                check_result();
            pending = replies_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the command bus bridge: host packets for every command with
// random content, returned read data, stray words, configuration changes
// between phases, random stalls on both streams and a final halt.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ucb_pkg::*;

    localparam int ADDR_W        = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int TARGET_ITEMS  = 120;
    localparam int NUM_OPS       = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        s_tuser   = ACT_RX;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_CONTROL_ADDR;
    logic [31:0] cfg_data  = '0;

    int error_count;
    int pending;
    int checked;

    int items_sent  = 0;
    int packets     = 0;
    int cfg_writes  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit gaps_on     = 1'b1;

    logic [7:0] ops [NUM_OPS] = '{CMD_WRITE_RND, CMD_WRITE, CMD_READ_RND, CMD_READ,
                                  CMD_WORD_WR, CMD_WORD_RD, CMD_START, CMD_TIME,
                                  CMD_STATUS, CMD_ECHO};

    uart_command_bus_bridge #(
        .ADDR_WIDTH(ADDR_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bridge_reply_checker #(
        .ADDR_WIDTH(ADDR_W)
    ) reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending),
        .checked     (checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: cycles with no word moving on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: no progress for %0d cycles", STALL_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output side: random stall bursts, calm stretches, one long hold-off
    initial
    begin : result_sink
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    repeat ($urandom_range(10, 40)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
        end
    end

    task automatic send_word(input logic act, input logic [7:0] rx, input logic [31:0] rd,
                             input bit counted);
        int gap;
        if (!quiet && gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {rd, rx};
        do @(posedge clk); while (!s_tready);
        if (counted)
            items_sent++;
    endtask

    task automatic send_packet(input logic [7:0] op, input logic [31:0] addr,
                               input logic [31:0] len);
        int n_data;
        bit is_read;
        n_data  = 0;
        is_read = 1'b0;
        send_word(ACT_RX, op, $urandom(), 1'b1);
        for (int i = 3; i >= 0; i--)
            send_word(ACT_RX, addr[8*i +: 8], $urandom(), 1'b1);
        for (int i = 3; i >= 0; i--)
            send_word(ACT_RX, len[8*i +: 8], $urandom(), 1'b1);
        case (op)
            CMD_WRITE_RND:
                n_data = (len + 32'd3) & ~32'd3;
            CMD_WRITE:
                n_data = len;
            CMD_READ_RND:
            begin
                n_data  = (len + 32'd3) & ~32'd3;
                is_read = 1'b1;
            end
            CMD_READ:
            begin
                n_data  = len;
                is_read = 1'b1;
            end
            CMD_WORD_WR:
                n_data = 4;
            CMD_WORD_RD, CMD_TIME, CMD_STATUS:
            begin
                n_data  = 1;
                is_read = 1'b1;
            end
            default: ;
        endcase
        for (int i = 0; i < n_data; i++)
        begin
            if (is_read)
            begin
                // serial byte arriving while the read is pending gets dropped
                if ($urandom_range(0, 5) == 0)
                    send_word(ACT_RX, 8'($urandom()), $urandom(), 1'b0);
                send_word(ACT_READ, 8'($urandom()), $urandom(), 1'b1);
            end
            else
                send_word(ACT_RX, 8'($urandom()), $urandom(), 1'b1);
        end
        packets++;
    endtask

    // wait until every predicted word is out, plus a margin for words that
    // cause nothing but may still sit in the input register
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin : stimulus
        int pkt;
        int op_base;
        logic [7:0]  op;
        logic [31:0] addr;
        logic [31:0] len;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme header echo, zero-size write, unknown code,
        // read data with nothing pending, padded write wrapping the address
        send_packet(CMD_ECHO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(CMD_WRITE, 32'h0000_0000, 32'd0);
        send_packet(8'h00, 32'h0000_0000, 32'h0000_0000);
        send_word(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_packet(CMD_WRITE_RND, 32'hFFFF_FFFE, 32'd1);

        drain();
        write_config(CFG_CONTROL_ADDR, 32'h0000_0000);
        write_config(CFG_TIME_ADDR, 32'hFFFF_FFFF);

        op_base = $urandom_range(0, NUM_OPS - 1);
        pkt = 0;
        while (items_sent < TARGET_ITEMS || pkt < NUM_OPS + 2)
        begin
            if (pkt % 4 == 3)
            begin
                drain();
                if (pkt / 4 == 1)
                begin
                    write_config(CFG_CONTROL_ADDR, 32'hFFFF_FFFF);
                    write_config(CFG_TIME_ADDR, 32'h0000_0000);
                end
                else
                begin
                    write_config(CFG_CONTROL_ADDR, $urandom());
                    write_config(CFG_TIME_ADDR, $urandom());
                end
            end
            gaps_on = $urandom_range(0, 3) != 0;
            if (pkt == 5)
            begin
                // long output hold while an echo packet and then further packets come in
                hold_req = 1'b1;
                send_packet(CMD_ECHO, $urandom(), $urandom());
            end

            op = ops[(op_base + pkt) % NUM_OPS];
            if ($urandom_range(0, 7) == 0)
                op = 8'h80 | 8'($urandom_range(0, 127));
            if ($urandom_range(0, 3) == 0)
                addr = 32'hFFFF_FFFF - $urandom_range(0, 6);
            else
                addr = $urandom();
            if (op == CMD_WRITE_RND || op == CMD_WRITE || op == CMD_READ_RND
                || op == CMD_READ)
                len = $urandom_range(0, 9);
            else
                len = $urandom();

            if ($urandom_range(0, 7) == 0)
                send_word(ACT_READ, 8'($urandom()), $urandom(), 1'b0);
            send_packet(op, addr, len);
            pkt++;
        end

        // last part: no idling, then halt and words that must be ignored
        drain();
        quiet = 1'b1;
        send_packet(CMD_ECHO, $urandom(), $urandom());
        send_packet(CMD_QUIT, $urandom(), $urandom());
        repeat (6)
            send_word(1'($urandom_range(0, 1)), 8'($urandom()), $urandom(), 1'b0);
        send_packet(CMD_ECHO, 32'h0000_0000, 32'h0000_0000);
        drain();

        $display("tb: %0d input words in %0d packets, %0d output words checked",
                 items_sent, packets, checked);
        $display("tb: all commands, unknown codes, stray words, %0d config writes, halt",
                 cfg_writes);
        if (error_count == 0 && pending == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/ucb_pkg.sv
sv/ucb_decode.sv
sv/ucb_outbuf.sv
sv/uart_command_bus_bridge.sv
tb/bridge_reply_checker.sv
tb/tb.sv
